// File: sv/cel_pkg.sv
// Package of shared types, constants and the logarithm table of the loss accumulator.
package cel_pkg;

  localparam int LN_TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(LN_TABLE_DEPTH);
  localparam int PROD_W = 16 + IDX_W;
  localparam int LN_W = 25;
  localparam int TERM_W = 28;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STEPS = 49;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS = 2'd1;

  localparam logic signed [29:0] LN_ZERO = -30'sd268435456;
  localparam logic signed [15:0] WEIGHT_ONE = 16'sd4096;

  typedef logic [LN_W-1:0] ln_tab_t [0:LN_TABLE_DEPTH];

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic kept;
    logic row_end;
    logic batch_end;
    logic clamp;
  } cel_item_t;

  typedef enum logic [2:0] {
    ST_ACC, ST_ROW, ST_FIN, ST_DIV, ST_SGN, ST_EMIT
  } cel_state_t;

  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic ln_tab_t ln_build();
    ln_tab_t t;
    longint unsigned d, den, y, y2, p, s, k;
    d = LN_TABLE_DEPTH;
    for (int i = 0; i <= LN_TABLE_DEPTH; i++) begin
      den = 2 * d + longint'(i);
      y = udiv((longint'(i) << 30) + (den >> 1), den);
      y2 = (y * y + (64'd1 << 29)) >> 30;
      p = y;
      s = 0;
      k = 1;
      for (int j = 0; j < 40; j++) begin
        if (p != 0) begin
          s = s + udiv(p, k);
          p = (p * y2 + (64'd1 << 29)) >> 30;
        end
        k = k + 2;
      end
      t[i] = LN_W'((2 * s + 32) >> 6);
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = ln_build();

endpackage

// File: sv/cel_if.sv
// Channel interfaces of the loss accumulator: input items, results and register writes.
interface cel_in_if;
  import cel_pkg::*;
  logic valid;
  logic ready;
  logic [15:0] prob;
  logic [15:0] target;
  logic signed [15:0] class_weight;
  logic row_kept;
  logic last_in_row;
  logic last_of_batch;
  modport source (output valid, prob, target, class_weight, row_kept, last_in_row,
                  last_of_batch, input ready);
  modport sink (input valid, prob, target, class_weight, row_kept, last_in_row,
                last_of_batch, output ready);
  modport monitor (input valid, ready, prob, target, class_weight, row_kept, last_in_row,
                   last_of_batch);
endinterface

interface cel_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] row_loss;
  logic signed [31:0] batch_loss;
  logic [15:0] kept_rows;
  logic saturated;
  logic final_res;
  modport source (output valid, row_loss, batch_loss, kept_rows, saturated, final_res,
                  input ready);
  modport sink (input valid, row_loss, batch_loss, kept_rows, saturated, final_res,
                output ready);
  modport monitor (input valid, ready, row_loss, batch_loss, kept_rows, saturated,
                   final_res);
endinterface

interface cel_cfg_if;
  import cel_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// File: sv/cel_front.sv
// Front pipeline: takes elements and computes each weighted log term.
module cel_front import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cel_in_if.sink    in_ch,
  input  logic      use_weights,
  input  logic      q_full,
  output logic      q_push,
  output cel_item_t q_item
);

  logic en;
  logic v1, v2, v3, v4, v5;

  logic [15:0] s1_prob, s1_target;
  logic signed [15:0] s1_w;
  logic s1_kept, s1_re, s1_be;

  logic [LN_W-1:0] s2_lo, s2_diff;
  logic [15:0] s2_rem, s2_target;
  logic [3:0] s2_sh;
  logic s2_zero;
  logic signed [15:0] s2_w;
  logic s2_kept, s2_re, s2_be;

  logic signed [29:0] s3_lnv;
  logic [15:0] s3_target;
  logic signed [15:0] s3_w;
  logic s3_kept, s3_re, s3_be, s3_clamp;

  logic [44:0] s4_p1;
  logic [15:0] s4_absw;
  logic s4_neg, s4_kept, s4_re, s4_be, s4_clamp;

  logic [3:0] e;
  logic [31:0] m_full;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0] idx_hi;
  logic [40:0] prod2;
  logic [LN_W-1:0] interp;
  logic [28:0] ln_base;
  logic signed [29:0] lnv;
  logic [28:0] absl;
  logic [60:0] p2;
  logic [25:0] mag;

  assign en = !v5 || !q_full;
  assign in_ch.ready = en;
  assign q_push = v5 && !q_full;

  always_comb begin
    e = 4'd0;
    for (int b = 1; b < 16; b++) begin
      if (s1_prob[b]) e = 4'(b);
    end
    m_full = 32'(s1_prob) << (5'd16 - {1'b0, e});
    prod = PROD_W'(m_full[15:0]) * PROD_W'(LN_TABLE_DEPTH);
    idx = prod[PROD_W-1:16];
    idx_hi = {1'b0, idx} + (IDX_W+1)'(1);
  end

  always_comb begin
    prod2 = 41'(s2_diff) * 41'(s2_rem) + 41'd32768;
    interp = s2_lo + LN_W'(prod2 >> 16);
    ln_base = 29'(s2_sh) * 29'(LN_TAB[LN_TABLE_DEPTH]);
    lnv = s2_zero ? LN_ZERO : (signed'(30'(interp)) - signed'(30'(ln_base)));
  end

  always_comb begin
    absl = (s3_lnv < 0) ? 29'(-s3_lnv) : 29'(s3_lnv);
    p2 = 61'(s4_p1) * 61'(s4_absw);
    mag = 26'((p2 + (61'd1 << 34)) >> 35);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    if (en) begin
      s1_prob <= in_ch.prob;
      s1_target <= in_ch.target;
      s1_w <= use_weights ? in_ch.class_weight : WEIGHT_ONE;
      s1_kept <= in_ch.row_kept;
      s1_re <= in_ch.last_in_row | in_ch.last_of_batch;
      s1_be <= in_ch.last_of_batch;

      s2_lo <= LN_TAB[idx];
      s2_diff <= LN_TAB[idx_hi] - LN_TAB[idx];
      s2_rem <= prod[15:0];
      s2_sh <= 4'd15 - e;
      s2_zero <= (s1_prob == 16'd0);
      s2_target <= s1_target;
      s2_w <= s1_w;
      s2_kept <= s1_kept;
      s2_re <= s1_re;
      s2_be <= s1_be;

      s3_lnv <= lnv;
      s3_target <= s2_target;
      s3_w <= s2_w;
      s3_kept <= s2_kept;
      s3_re <= s2_re;
      s3_be <= s2_be;
      s3_clamp <= s2_zero && (s2_target != 16'd0) && s2_kept;

      s4_p1 <= 45'(absl) * 45'(s3_target);
      s4_absw <= (s3_w < 0) ? 16'(-s3_w) : 16'(s3_w);
      s4_neg <= (s3_lnv > 0) != (s3_w < 0);
      s4_kept <= s3_kept;
      s4_re <= s3_re;
      s4_be <= s3_be;
      s4_clamp <= s3_clamp;

      q_item.term <= s4_neg ? -signed'(TERM_W'(mag)) : signed'(TERM_W'(mag));
      q_item.kept <= s4_kept;
      q_item.row_end <= s4_re;
      q_item.batch_end <= s4_be;
      q_item.clamp <= s4_clamp;
    end
  end

endmodule

// File: sv/cel_fifo.sv
// Short queue of computed terms between the front pipeline and the accumulator.
module cel_fifo import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cel_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output cel_item_t head
);

  cel_item_t mem [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      if (push && !pop) count <= count + FIFO_CNT_W'(1);
      else if (pop && !push) count <= count - FIFO_CNT_W'(1);
    end
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

// File: sv/cel_back.sv
// Accumulator: row and batch sums, the mean divider and the result register.
module cel_back import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mean_en,
  input  logic      q_valid,
  input  cel_item_t q_item,
  output logic      q_pop,
  cel_out_if.source out_ch
);

  cel_state_t state, state_next;
  logic signed [39:0] row_sum;
  logic signed [47:0] batch_sum;
  logic [15:0] row_counter;
  logic clamp_flag;
  logic cur_kept, cur_be;
  logic signed [31:0] row_loss, batch_loss;
  logic [48:0] div_num;
  logic [16:0] div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic div_neg;
  logic emit_fire;

  logic o_valid;
  logic signed [31:0] o_row, o_batch;
  logic [15:0] o_kept;
  logic o_sat, o_final;

  logic signed [40:0] rs_add;
  logic signed [39:0] rs_sat;
  logic rs_ovf;
  logic signed [31:0] rl_sat;
  logic rl_ovf;
  logic signed [48:0] bs_add;
  logic signed [47:0] bs_sat;
  logic bs_ovf;
  logic signed [31:0] bl_sat;
  logic bl_ovf;
  logic [47:0] bs_abs;
  logic [16:0] rem_sh;
  logic div_bit;
  logic signed [49:0] q_signed;
  logic signed [31:0] q_sat;
  logic q_ovf;

  assign out_ch.valid = o_valid;
  assign out_ch.row_loss = o_row;
  assign out_ch.batch_loss = o_batch;
  assign out_ch.kept_rows = o_kept;
  assign out_ch.saturated = o_sat;
  assign out_ch.final_res = o_final;

  always_comb begin
    rs_add = 41'(row_sum) + 41'(q_item.term);
    rs_ovf = 1'b1;
    if (rs_add > 41'sd549755813887) rs_sat = 40'sh7FFFFFFFFF;
    else if (rs_add < -41'sd549755813888) rs_sat = 40'sh8000000000;
    else begin
      rs_sat = 40'(rs_add);
      rs_ovf = 1'b0;
    end

    rl_ovf = 1'b1;
    if (row_sum > 40'sd2147483647) rl_sat = 32'sh7FFFFFFF;
    else if (row_sum < -40'sd2147483648) rl_sat = 32'sh80000000;
    else begin
      rl_sat = 32'(row_sum);
      rl_ovf = 1'b0;
    end

    bs_add = 49'(batch_sum) + 49'(rl_sat);
    bs_ovf = 1'b1;
    if (bs_add > 49'sd140737488355327) bs_sat = 48'sh7FFFFFFFFFFF;
    else if (bs_add < -49'sd140737488355328) bs_sat = 48'sh800000000000;
    else begin
      bs_sat = 48'(bs_add);
      bs_ovf = 1'b0;
    end

    bl_ovf = 1'b1;
    if (batch_sum > 48'sd2147483647) bl_sat = 32'sh7FFFFFFF;
    else if (batch_sum < -48'sd2147483648) bl_sat = 32'sh80000000;
    else begin
      bl_sat = 32'(batch_sum);
      bl_ovf = 1'b0;
    end

    bs_abs = (batch_sum < 0) ? 48'(-batch_sum) : 48'(batch_sum);
    rem_sh = {div_rem[15:0], div_num[48]};
    div_bit = (rem_sh >= {1'b0, row_counter});

    q_signed = div_neg ? -signed'(50'(div_num)) : signed'(50'(div_num));
    q_ovf = 1'b1;
    if (q_signed > 50'sd2147483647) q_sat = 32'sh7FFFFFFF;
    else if (q_signed < -50'sd2147483648) q_sat = 32'sh80000000;
    else begin
      q_sat = 32'(q_signed);
      q_ovf = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_ACC: if (q_valid && q_item.row_end) state_next = ST_ROW;
      ST_ROW: state_next = cur_be ? ST_FIN : ST_EMIT;
      ST_FIN: state_next = (mean_en && row_counter != 16'd0) ? ST_DIV : ST_EMIT;
      ST_DIV: if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_SGN;
      ST_SGN: state_next = ST_EMIT;
      ST_EMIT: if (!o_valid || out_ch.ready) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  always_comb begin
    q_pop = (state == ST_ACC) && q_valid;
    emit_fire = (state == ST_EMIT) && (!o_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      row_sum <= '0;
      batch_sum <= '0;
      row_counter <= '0;
      clamp_flag <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_ACC: begin
          if (q_pop) begin
            cur_kept <= q_item.kept;
            cur_be <= q_item.batch_end;
            if (q_item.kept) begin
              row_sum <= rs_sat;
              clamp_flag <= clamp_flag | q_item.clamp | rs_ovf;
            end
          end
        end
        ST_ROW: begin
          batch_loss <= '0;
          row_sum <= '0;
          if (cur_kept) begin
            row_loss <= rl_sat;
            batch_sum <= bs_sat;
            if (row_counter != 16'hFFFF) row_counter <= row_counter + 16'd1;
            clamp_flag <= clamp_flag | rl_ovf | bs_ovf;
          end else begin
            row_loss <= '0;
          end
        end
        ST_FIN: begin
          if (!mean_en) begin
            batch_loss <= bl_sat;
            clamp_flag <= clamp_flag | bl_ovf;
          end else begin
            div_num <= 49'(bs_abs) + 49'(row_counter >> 1);
            div_rem <= '0;
            div_cnt <= '0;
            div_neg <= (batch_sum < 0);
          end
        end
        ST_DIV: begin
          div_rem <= div_bit ? (rem_sh - {1'b0, row_counter}) : rem_sh;
          div_num <= {div_num[47:0], div_bit};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        ST_SGN: begin
          batch_loss <= q_sat;
          clamp_flag <= clamp_flag | q_ovf;
        end
        ST_EMIT: begin
          if (emit_fire && cur_be) begin
            batch_sum <= '0;
            row_counter <= '0;
            clamp_flag <= 1'b0;
          end
        end
        default: ;
      endcase
      if (emit_fire) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
    end
    if (emit_fire) begin
      o_row <= row_loss;
      o_batch <= cur_be ? batch_loss : 32'sd0;
      o_kept <= row_counter;
      o_sat <= clamp_flag;
      o_final <= cur_be;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_rem < {1'b0, row_counter})
    else $error("divider remainder not below divisor");
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> row_sum == 40'sd0)
    else $error("row sum not cleared at batch end");
  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    emit_fire && cur_be |=> row_counter == 16'd0 && !clamp_flag && batch_sum == 48'sd0)
    else $error("batch state not cleared after final result");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_item.row_end |=> state == ST_ROW)
    else $error("row end not handled");
`endif

endmodule

// File: sv/cross_entropy_loss_accumulator_top.sv
// Top level of the weighted, masked cross-entropy loss accumulator.
// Each element passes a five-stage log and multiply pipeline, then a queue of four.
// Elements that do not end a row are taken one per cycle while the queue is not full; a row
// end takes the accumulator through its row and emit states, a batch end also through finish,
// and mean reduction adds the divider and sign states; results are registered in the emit state.
// Synchronous reset clears sums, counters, flags and both registers to zero.
module cross_entropy_loss_accumulator_top import cel_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cel_in_if.sink    in_ch,
  cel_out_if.source out_ch,
  cel_cfg_if.sink   cfg
);

  logic mean_en, use_weights;
  logic q_full, q_push, q_pop, q_valid;
  cel_item_t q_in, q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_en <= 1'b0;
      use_weights <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MEAN_EN) mean_en <= cfg.data;
      if (cfg.index == REG_USE_WEIGHTS) use_weights <= cfg.data;
    end
  end

  cel_front u_front (
    .clk, .rst, .in_ch, .use_weights,
    .q_full, .q_push, .q_item(q_in)
  );

  cel_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  cel_back u_back (
    .clk, .rst, .mean_en, .q_valid, .q_item(q_head), .q_pop, .out_ch
  );

endmodule
